>>> rtl/core/sorted_priority_queue_defines.svh
// Assertion helpers for the checker file.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked on clk, quiet during reset.
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication, checked on clk, quiet during reset.
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

>>> rtl/core/spq_pkg.sv
package spq_pkg;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int unsigned DATA_BITS = 8;
  localparam int unsigned CAP_BITS  = 5;
  localparam int unsigned OUT_COUNT_BITS = 5;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // accepted insert that fits
    logic rem;  // accepted remove of a present head
  } spq_ctl_t;

endpackage

>>> rtl/core/spq_cell.sv
module spq_cell #(
  parameter int IDX = 0,
  parameter int PW  = 8,
  parameter int CW  = 5
) (
  input  logic                         clk,
  input  spq_pkg::spq_ctl_t            ctl,
  input  logic [CW-1:0]                count,
  input  logic [PW-1:0]                new_prio,
  input  logic [spq_pkg::DATA_BITS-1:0] new_char,
  input  logic                         left_gt,
  input  logic [PW-1:0]                left_prio,
  input  logic [spq_pkg::DATA_BITS-1:0] left_char,
  input  logic [PW-1:0]                right_prio,
  input  logic [spq_pkg::DATA_BITS-1:0] right_char,
  output logic                         gt,
  output logic [PW-1:0]                prio,
  output logic [spq_pkg::DATA_BITS-1:0] chr
);
  import spq_pkg::*;

  logic occ;
  logic at_tail;
  logic [PW-1:0]        prio_next;
  logic [DATA_BITS-1:0] chr_next;

  assign occ     = (count > CW'(IDX));
  assign at_tail = (count == CW'(IDX));
  // stored entry sorts behind the incoming one
  assign gt      = occ && (prio > new_prio);

  always_comb begin
    prio_next = prio;
    chr_next  = chr;
    if (ctl.ins) begin
      if (left_gt) begin
        prio_next = left_prio;
        chr_next  = left_char;
      end else if (gt || at_tail) begin
        prio_next = new_prio;
        chr_next  = new_char;
      end
    end else if (ctl.rem) begin
      prio_next = right_prio;
      chr_next  = right_char;
    end
  end

  always_ff @(posedge clk) begin
    prio <= prio_next;
    chr  <= chr_next;
  end

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Sorted priority queue of (priority, character) items, head first in a row
// of DEPTH cells. Pulse start while busy is low to issue one item: op 0
// inserts new_prio/new_char behind every stored entry of lower or equal
// priority, op 1 removes the head (smallest priority). In the next cycle
// done pulses for one cycle with out_prio/out_char (zero unless a
// remove succeeded), status (0 done, 1 full, 2 empty) and count_after. The
// receiver cannot stall, so take the result in that cycle. One item per
// cycle is sustained: every cell compares against the new priority and
// moves in the same cycle, so the row's single compare-and-shift step sets
// the rate. busy is high only while in reset and for the cycle after it.
// capacity (cfg_we/cfg_data, reset 16) limits the fill; values above DEPTH
// act as DEPTH, zero refuses every insert.
module sorted_priority_queue #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             op,
  input  logic [7:0]                       new_prio,
  input  logic [spq_pkg::DATA_BITS-1:0]    new_char,
  input  logic                             cfg_we,
  input  logic [spq_pkg::CAP_BITS-1:0]     cfg_data,
  output logic                             done,
  output logic [7:0]                       out_prio,
  output logic [spq_pkg::DATA_BITS-1:0]    out_char,
  output logic [1:0]                       status,
  output logic [spq_pkg::OUT_COUNT_BITS-1:0] count_after
);
  import spq_pkg::*;

  // stored priority width: only the low PRIO_BITS (at most 8) of the input are kept
  localparam int PW   = (PRIO_BITS < 8) ? PRIO_BITS : 8;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

  logic [CAP_BITS-1:0] capacity;
  logic [CW-1:0]       count, count_next;
  logic [CMPW-1:0]     cap_eff;
  logic                accept, full, empty;
  logic [PW-1:0]       prio_in;
  spq_ctl_t            ctl;

  // cell row taps, each read at its own fixed neighbor
  logic [PW-1:0]        cell_prio [DEPTH];
  logic [DATA_BITS-1:0] cell_char [DEPTH];
  logic                 cell_gt   [DEPTH];

  assign accept  = start && !busy;
  assign prio_in = new_prio[PW-1:0];
  assign cap_eff = (CMPW'(capacity) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(capacity);
  assign full    = (CMPW'(count) >= cap_eff);
  assign empty   = (count == '0);

  assign ctl.ins = accept && (op == OP_INSERT) && !full;
  assign ctl.rem = accept && (op == OP_REMOVE) && !empty;

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CW'(1);
    end else if (ctl.rem) begin
      count_next = count - CW'(1);
    end
  end

  // cell 0 is the head; insert shifts toward the tail, remove toward the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_gt;
    logic [PW-1:0]        l_prio, r_prio;
    logic [DATA_BITS-1:0] l_char, r_char;

    if (i == 0) begin : g_head
      assign l_gt   = 1'b0;
      assign l_prio = '0;
      assign l_char = '0;
    end else begin : g_body
      assign l_gt   = cell_gt[i-1];
      assign l_prio = cell_prio[i-1];
      assign l_char = cell_char[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_prio = cell_prio[i];
      assign r_char = cell_char[i];
    end else begin : g_mid
      assign r_prio = cell_prio[i+1];
      assign r_char = cell_char[i+1];
    end

    spq_cell #(
      .IDX (i),
      .PW  (PW),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count),
      .new_prio   (prio_in),
      .new_char   (new_char),
      .left_gt    (l_gt),
      .left_prio  (l_prio),
      .left_char  (l_char),
      .right_prio (r_prio),
      .right_char (r_char),
      .gt         (cell_gt[i]),
      .prio       (cell_prio[i]),
      .chr        (cell_char[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      done     <= 1'b0;
      count    <= '0;
      capacity <= CAP_BITS'(16);
    end else begin
      busy  <= 1'b0;
      done  <= accept;
      count <= count_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
    end
  end

  // result payload, loaded on every accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      count_after <= OUT_COUNT_BITS'(count_next);
      if (ctl.rem) begin
        out_prio <= 8'(cell_prio[0]);
        out_char <= cell_char[0];
      end else begin
        out_prio <= '0;
        out_char <= '0;
      end
      if (op == OP_INSERT) begin
        status <= full ? ST_FULL : ST_DONE;
      end else begin
        status <= empty ? ST_EMPTY : ST_DONE;
      end
    end
  end

endmodule

>>> rtl/core/spq_check.sv
`include "sorted_priority_queue_defines.svh"

module spq_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             op,
  input logic                             done,
  input logic [7:0]                       out_prio,
  input logic [spq_pkg::DATA_BITS-1:0]    out_char,
  input logic [1:0]                       status,
  input logic [spq_pkg::OUT_COUNT_BITS-1:0] count_after
);
  import spq_pkg::*;

  // every accepted item gives a result in the next cycle
  `SPQ_ASSERT_NXT(a_result_follows, start && !busy, done)
  // no result without an accepted item just before
  `SPQ_ASSERT_IMP(a_no_spurious, done, $past(start && !busy))
  // inserts never return an entry and never report empty
  `SPQ_ASSERT_NXT(a_insert_result, start && !busy && op == OP_INSERT,
    out_prio == 8'd0 && out_char == '0 && status != ST_EMPTY)
  // removes never report full; an empty report leaves the count at zero
  `SPQ_ASSERT_NXT(a_remove_result, start && !busy && op == OP_REMOVE,
    status != ST_FULL && (status != ST_EMPTY || count_after == '0))

endmodule

bind sorted_priority_queue spq_check u_spq_check (.*);
